>>> rtl/core/pfd_pkg.sv
// Shared types, constants and the CRC-32 byte step for the packet frame deframer.
package pfd_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Frame status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_SOF_EOF   = 3'd2;
    localparam logic [2:0] ST_LENGTH    = 3'd3;
    localparam logic [2:0] ST_CRC       = 3'd4;

    // Frame delimiters.
    localparam logic [7:0]  SOF_BYTES [4] = '{8'h3f, 8'h6c, 8'h81, 8'h29};
    localparam logic [31:0] EOF_WORD      = 32'h681a5b90;

    // CRC-32, reflected.
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Frame byte counter saturates at its all-ones value.
    localparam int unsigned COUNT_W   = 25;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Result queue geometry.
    localparam int unsigned RES_DEPTH = 4;
    localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
    localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] app_id;
        logic [3:0]  step_id;
        logic [3:0]  msg_version;
        logic [63:0] seq_id;
        logic [7:0]  payload_byte;
        logic        element_end;
        logic [3:0]  frame_version;
        logic [2:0]  status;
        logic        out_last;
    } res_t;

    // Results produced by one input item, packed from the first slot.
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

    // One byte of the reflected CRC-32 update.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/pfd_parser.sv
// Frame parser: holds the per-frame state and forms the results of each byte.
module pfd_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output pfd_pkg::push_t       push
);

    // Parse phases.
    localparam logic [2:0] PH_HDR    = 3'd0;
    localparam logic [2:0] PH_MSGHDR = 3'd1;
    localparam logic [2:0] PH_LENHI  = 3'd2;
    localparam logic [2:0] PH_LENLO  = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_END    = 3'd5;
    localparam logic [2:0] PH_TRAIL  = 3'd6;
    localparam logic [2:0] PH_SKIP   = 3'd7;

    localparam int unsigned CW = pfd_pkg::COUNT_W;

    logic [2:0]    phase_reg, phase_next;
    logic [CW-1:0] count_reg, count_next;
    logic [23:0]   plen_reg, plen_next;
    logic [23:0]   mrem_reg, mrem_next;
    logic [15:0]   erem_reg, erem_next;
    logic [63:0]   seq_reg, seq_next;
    logic [23:0]   ids_reg, ids_next;
    logic [31:0]   crc_reg, crc_next;
    logic [31:0]   tail_reg, tail_next;
    logic          sof_err_reg, sof_err_next;
    logic          str_err_reg, str_err_next;
    logic [3:0]    fver_reg, fver_next;
    logic [31:0]   crc_rx_reg, crc_rx_next;

    logic [CW-1:0] pos;
    logic [CW:0]   region_end;
    logic [CW:0]   diff;
    logic [CW:0]   room;
    logic          crc_en;
    logic          after_elem;
    logic          emit_rec;
    logic [1:0]    rec_kind;
    logic [7:0]    rec_pay;
    logic          rec_eend;
    logic [2:0]    st;
    logic [15:0]   erem_lo;
    pfd_pkg::res_t rec;
    pfd_pkg::res_t stat;

    // Next-state logic for one accepted byte.
    always_comb
    begin
        phase_next   = phase_reg;
        plen_next    = plen_reg;
        mrem_next    = mrem_reg;
        erem_next    = erem_reg;
        seq_next     = seq_reg;
        ids_next     = ids_reg;
        sof_err_next = sof_err_reg;
        str_err_next = str_err_reg;
        fver_next    = fver_reg;
        crc_rx_next  = crc_rx_reg;
        after_elem   = 1'b0;
        emit_rec     = 1'b0;
        rec_kind     = pfd_pkg::KIND_HEADER;
        rec_pay      = 8'd0;
        rec_eend     = 1'b0;
        erem_lo      = '0;

        pos        = count_reg;
        region_end = (CW+1)'(8) + {{(CW+1-24){1'b0}}, plen_reg};
        diff       = region_end - {1'b0, pos};
        room       = diff - (CW+1)'(1);
        count_next = (count_reg != pfd_pkg::COUNT_MAX) ? count_reg + CW'(1) : count_reg;
        tail_next  = {tail_reg[23:0], in_byte};

        // The CRC covers the version byte through the last message byte.
        crc_en   = ((phase_reg == PH_HDR) && (pos >= CW'(4))) ||
                   (phase_reg inside {PH_MSGHDR, PH_LENHI, PH_LENLO, PH_DATA});
        crc_next = crc_en ? pfd_pkg::crc32_byte(crc_reg, in_byte) : crc_reg;

        case (phase_reg)
            PH_HDR:
            begin
                if (pos < CW'(4))
                begin
                    if (in_byte != pfd_pkg::SOF_BYTES[pos[1:0]])
                        sof_err_next = 1'b1;
                end
                else if (pos == CW'(4))
                begin
                    fver_next = in_byte[3:0];
                end
                else
                begin
                    plen_next = {plen_reg[15:0], in_byte};
                    if (pos == CW'(7))
                    begin
                        phase_next = (plen_next == 24'd0) ? PH_END : PH_MSGHDR;
                        erem_next  = 16'd0;
                    end
                end
            end
            PH_MSGHDR:
            begin
                if ((erem_reg == 16'd0) && (diff < (CW+1)'(14)))
                begin
                    str_err_next = 1'b1;
                    phase_next   = PH_SKIP;
                end
                else
                begin
                    if (erem_reg == 16'd0)
                        mrem_next = 24'd0;
                    if (erem_reg < 16'd3)
                        ids_next = {ids_reg[15:0], in_byte};
                    else if (erem_reg < 16'd11)
                        seq_next = {seq_reg[55:0], in_byte};
                    else
                        mrem_next = {mrem_next[15:0], in_byte};
                    if (erem_reg >= 16'd13)
                    begin
                        if ({{(CW+1-24){1'b0}}, mrem_next} > room)
                        begin
                            str_err_next = 1'b1;
                            phase_next   = PH_SKIP;
                        end
                        else
                        begin
                            emit_rec   = 1'b1;
                            rec_kind   = pfd_pkg::KIND_HEADER;
                            after_elem = 1'b1;
                        end
                    end
                    else
                    begin
                        erem_next = erem_reg + 16'd1;
                    end
                end
            end
            PH_LENHI:
            begin
                if (mrem_reg < 24'd2)
                begin
                    str_err_next = 1'b1;
                    phase_next   = PH_SKIP;
                end
                else
                begin
                    erem_next  = {in_byte, 8'd0};
                    mrem_next  = mrem_reg - 24'd1;
                    phase_next = PH_LENLO;
                end
            end
            PH_LENLO:
            begin
                erem_lo   = erem_reg | {8'd0, in_byte};
                erem_next = erem_lo;
                mrem_next = mrem_reg - 24'd1;
                if ({8'd0, erem_lo} > mrem_next)
                begin
                    str_err_next = 1'b1;
                    phase_next   = PH_SKIP;
                end
                else if (erem_lo == 16'd0)
                begin
                    after_elem = 1'b1;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                erem_next = erem_reg - 16'd1;
                mrem_next = mrem_reg - 24'd1;
                emit_rec  = 1'b1;
                rec_kind  = pfd_pkg::KIND_PAYLOAD;
                rec_pay   = in_byte;
                rec_eend  = (erem_next == 16'd0);
                if (erem_next == 16'd0)
                    after_elem = 1'b1;
            end
            PH_END:
            begin
                if (erem_reg == 16'd3)
                    crc_rx_next = tail_next;
                if (erem_reg >= 16'd7)
                    phase_next = PH_TRAIL;
                else
                    erem_next = erem_reg + 16'd1;
            end
            default:
            begin
            end
        endcase

        // End of an element or of a message header: pick what follows.
        if (after_elem)
        begin
            if (mrem_next != 24'd0)
            begin
                phase_next = PH_LENHI;
            end
            else if (({1'b0, pos} + (CW+1)'(1)) == region_end)
            begin
                phase_next = PH_END;
                erem_next  = 16'd0;
            end
            else
            begin
                phase_next = PH_MSGHDR;
                erem_next  = 16'd0;
            end
        end

        // Frame status, in order of precedence.
        if (count_next < CW'(8))
            st = pfd_pkg::ST_SHORT;
        else if (sof_err_next || (tail_next != pfd_pkg::EOF_WORD))
            st = pfd_pkg::ST_SOF_EOF;
        else if (str_err_next || (phase_next != PH_TRAIL))
            st = pfd_pkg::ST_LENGTH;
        else if ((crc_next ^ pfd_pkg::CRC_INIT) != crc_rx_next)
            st = pfd_pkg::ST_CRC;
        else
            st = pfd_pkg::ST_OK;
    end

    // Result items: a record from the parse, then the status at frame end.
    always_comb
    begin
        rec.kind          = rec_kind;
        rec.app_id        = ids_next[23:8];
        rec.step_id       = ids_next[7:4];
        rec.msg_version   = ids_next[3:0];
        rec.seq_id        = seq_next;
        rec.payload_byte  = rec_pay;
        rec.element_end   = rec_eend;
        rec.frame_version = fver_next;
        rec.status        = pfd_pkg::ST_OK;
        rec.out_last      = !in_last;

        stat.kind          = pfd_pkg::KIND_STATUS;
        stat.app_id        = 16'd0;
        stat.step_id       = 4'd0;
        stat.msg_version   = 4'd0;
        stat.seq_id        = 64'd0;
        stat.payload_byte  = 8'd0;
        stat.element_end   = 1'b0;
        stat.frame_version = fver_next;
        stat.status        = st;
        stat.out_last      = 1'b1;

        push.second = stat;
        if (emit_rec)
        begin
            push.first = rec;
            push.count = in_last ? 2'd2 : 2'd1;
        end
        else
        begin
            push.first = stat;
            push.count = in_last ? 2'd1 : 2'd0;
        end
        if (!accept)
            push.count = 2'd0;
    end

    // State registers; the frame state returns to reset after the last byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR;
            count_reg   <= '0;
            plen_reg    <= '0;
            mrem_reg    <= '0;
            erem_reg    <= '0;
            seq_reg     <= '0;
            ids_reg     <= '0;
            crc_reg     <= pfd_pkg::CRC_INIT;
            tail_reg    <= '0;
            sof_err_reg <= 1'b0;
            str_err_reg <= 1'b0;
            fver_reg    <= '0;
            crc_rx_reg  <= '0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                phase_reg   <= PH_HDR;
                count_reg   <= '0;
                plen_reg    <= '0;
                mrem_reg    <= '0;
                erem_reg    <= '0;
                seq_reg     <= '0;
                ids_reg     <= '0;
                crc_reg     <= pfd_pkg::CRC_INIT;
                tail_reg    <= '0;
                sof_err_reg <= 1'b0;
                str_err_reg <= 1'b0;
                fver_reg    <= '0;
                crc_rx_reg  <= '0;
            end
            else
            begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                plen_reg    <= plen_next;
                mrem_reg    <= mrem_next;
                erem_reg    <= erem_next;
                seq_reg     <= seq_next;
                ids_reg     <= ids_next;
                crc_reg     <= crc_next;
                tail_reg    <= tail_next;
                sof_err_reg <= sof_err_next;
                str_err_reg <= str_err_next;
                fver_reg    <= fver_next;
                crc_rx_reg  <= crc_rx_next;
            end
        end
    end

endmodule

>>> rtl/core/pfd_res_fifo.sv
// Result queue: takes up to two items per cycle and hands out one.
module pfd_res_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  pfd_pkg::push_t push,
    output logic           space,
    output logic           out_valid,
    input  logic           out_ready,
    output pfd_pkg::res_t  head
);

    localparam int unsigned PW = pfd_pkg::RES_PTR_W;
    localparam int unsigned CW = pfd_pkg::RES_CNT_W;

    pfd_pkg::res_t  mem_reg [pfd_pkg::RES_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           pop;

    // Room for the two results one input item may cause.
    assign space     = (cnt_reg <= CW'(pfd_pkg::RES_DEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and fill arithmetic.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.count);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        cnt_next    = cnt_reg + CW'(push.count) - CW'(pop);
    end

    // Storage writes.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_reg + PW'(1)] <= push.second;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> rtl/core/packet_frame_deframer_top.sv
// Top level of the packet frame deframer.
//
// Input channel: one frame byte per item on in_byte, with in_last set on the
// final byte of the frame; handshake in_valid/in_ready.
// Output channel: result items (message header record, payload byte record or
// frame status) on the result ports; handshake out_valid/out_ready. out_last
// marks the last result caused by one input byte.
// A result is visible on the output in the cycle after its byte is accepted
// when the queue is empty.
// Throughput: one byte per cycle while in_ready is high. A byte causes at
// most two results, a record and the frame status when the frame ends on a
// header or payload byte; they leave one at a time through the single
// output port of the four-entry result queue.
// in_ready depends only on the fill of that queue: it is high while two
// entries are free, so a stalled receiver holds back the sender once more
// than two results are pending, and nothing is lost.
// Reset clears the parser to the frame start and empties the queue. After
// each status item the frame state returns to its reset value by itself.
// Payload records are passed on before the frame is checked; the status
// item decides whether they are to be trusted.
module packet_frame_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] app_id,
    output logic [3:0]  step_id,
    output logic [3:0]  msg_version,
    output logic [63:0] seq_id,
    output logic [7:0]  payload_byte,
    output logic        element_end,
    output logic [3:0]  frame_version,
    output logic [2:0]  status,
    output logic        out_last
);

    pfd_pkg::push_t push;
    pfd_pkg::res_t  head;
    logic           space;
    logic           accept;

    assign in_ready = space;
    assign accept   = in_valid && space;

    // Parser with the per-frame state.
    pfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .in_last (in_last),
        .push    (push)
    );

    // Result queue towards the receiver.
    pfd_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    // Result fields.
    assign kind          = head.kind;
    assign app_id        = head.app_id;
    assign step_id       = head.step_id;
    assign msg_version   = head.msg_version;
    assign seq_id        = head.seq_id;
    assign payload_byte  = head.payload_byte;
    assign element_end   = head.element_end;
    assign frame_version = head.frame_version;
    assign status        = head.status;
    assign out_last      = head.out_last;

endmodule

>>> tb/tb_packet_frame_deframer_top.sv
// Self-checking testbench for the packet frame deframer: random framed traffic against a predictor.
module tb_packet_frame_deframer_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int unsigned RANDOM_BYTES = 900;
    localparam int unsigned HOLD_AT      = 200;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Parser phases of the predictor.
    localparam logic [3:0] PH_SOF_HDR = 4'd0;
    localparam logic [3:0] PH_MSG_HDR = 4'd1;
    localparam logic [3:0] PH_ELEN_HI = 4'd2;
    localparam logic [3:0] PH_ELEN_LO = 4'd3;
    localparam logic [3:0] PH_PAYLOAD = 4'd4;
    localparam logic [3:0] PH_TRAILER = 4'd5;
    localparam logic [3:0] PH_TAIL    = 4'd6;
    localparam logic [3:0] PH_DISCARD = 4'd7;

    // One frame byte waiting to be sent.
    typedef struct {
        logic [7:0]  data;
        logic        lst;
        int unsigned gap;
        bit          drain;
    } frame_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'h00;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [15:0] app_id;
    logic [3:0]  step_id;
    logic [3:0]  msg_version;
    logic [63:0] seq_id;
    logic [7:0]  payload_byte;
    logic        element_end;
    logic [3:0]  frame_version;
    logic [2:0]  status;
    logic        out_last;

    frame_byte_t   pending_bytes[$];
    pfd_pkg::res_t expected_results[$];
    logic [7:0]    frame_bytes[$];
    int            errors = 0;
    int unsigned   results_seen = 0;
    int unsigned   rx_wait = 0;
    int unsigned   rx_mode = 0;
    int unsigned   cycles = 0;

    // Predictor copy of the parser state.
    logic [3:0]                  ph;
    logic [pfd_pkg::COUNT_W-1:0] byte_cnt;
    logic [23:0]                 pkt_len;
    logic [23:0]                 msg_left;
    logic [15:0]                 elem_idx;
    logic [63:0]                 seq_reg;
    logic [23:0]                 ids_reg;
    logic [31:0]                 crc_reg;
    logic [63:0]                 tail_reg;
    logic [2:0]                  err_flags;
    logic [3:0]                  fver_reg;
    logic [31:0]                 crc_rx;

    packet_frame_deframer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .in_last       (in_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .app_id        (app_id),
        .step_id       (step_id),
        .msg_version   (msg_version),
        .seq_id        (seq_id),
        .payload_byte  (payload_byte),
        .element_end   (element_end),
        .frame_version (frame_version),
        .status        (status),
        .out_last      (out_last)
    );

    // Clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Bit-serial reflected CRC-32 over one byte.
    function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        r = c;
        for (int i = 0; i < 8; i++)
        begin
            if (r[0] ^ d[i])
                r = (r >> 1) ^ pfd_pkg::CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    // Return the predictor to the start of a frame.
    function automatic void parser_clear();
        ph        = PH_SOF_HDR;
        byte_cnt  = '0;
        pkt_len   = '0;
        msg_left  = '0;
        elem_idx  = '0;
        seq_reg   = '0;
        ids_reg   = '0;
        crc_reg   = pfd_pkg::CRC_INIT;
        tail_reg  = '0;
        err_flags = '0;
        fver_reg  = '0;
        crc_rx    = '0;
    endfunction

    // A malformed structure stops parsing for the rest of the frame.
    function automatic void abandon_frame();
        err_flags[1] = 1'b1;
        ph = PH_DISCARD;
    endfunction

    // Decide what follows a finished element or message header.
    function automatic void close_element(input logic [31:0] pos, input logic [31:0] region_end);
        if (msg_left != 0)
            ph = PH_ELEN_HI;
        else
        begin
            if (pos + 32'd1 == region_end)
                ph = PH_TRAILER;
            else
                ph = PH_MSG_HDR;
            elem_idx = '0;
        end
    endfunction

    // Build one result item from the current message and frame state.
    function automatic pfd_pkg::res_t make_record(input logic [1:0] k, input logic [7:0] pay,
                                                  input logic eend, input logic [2:0] st);
        pfd_pkg::res_t r;
        r = '0;
        r.kind          = k;
        r.payload_byte  = pay;
        r.element_end   = eend;
        r.frame_version = fver_reg;
        r.status        = st;
        if (k != pfd_pkg::KIND_STATUS)
        begin
            r.app_id      = ids_reg[23:8];
            r.step_id     = ids_reg[7:4];
            r.msg_version = ids_reg[3:0];
            r.seq_id      = seq_reg;
        end
        return r;
    endfunction

    // Advance the parser by one byte and queue the records that it yields.
    function automatic void predict_records(input logic [7:0] b, input logic lst);
        logic [31:0]   pos;
        logic [31:0]   region_end;
        logic [31:0]   sub;
        logic [2:0]    st;
        pfd_pkg::res_t batch[$];
        pos = 32'(byte_cnt);
        region_end = 32'd8 + 32'(pkt_len);
        if (byte_cnt != pfd_pkg::COUNT_MAX)
            byte_cnt = byte_cnt + pfd_pkg::COUNT_W'(1);
        tail_reg = {tail_reg[55:0], b};

        // The CRC covers the version byte up to the last message byte.
        if ((ph == PH_SOF_HDR && pos >= 32'd4) || ph == PH_MSG_HDR || ph == PH_ELEN_HI ||
            ph == PH_ELEN_LO || ph == PH_PAYLOAD)
            crc_reg = crc_update(crc_reg, b);

        case (ph)
            PH_SOF_HDR:
            begin
                if (pos < 32'd4)
                begin
                    if (b != pfd_pkg::SOF_BYTES[pos[1:0]])
                        err_flags[0] = 1'b1;
                end
                else if (pos == 32'd4)
                    fver_reg = b[3:0];
                else
                begin
                    pkt_len = {pkt_len[15:0], b};
                    if (pos == 32'd7)
                    begin
                        if (pkt_len == 0)
                            ph = PH_TRAILER;
                        else
                            ph = PH_MSG_HDR;
                        elem_idx = '0;
                    end
                end
            end
            PH_MSG_HDR:
            begin
                sub = 32'(elem_idx);
                if (sub == 0 && region_end - pos < 32'd14)
                    abandon_frame();
                else
                begin
                    if (sub == 0)
                        msg_left = '0;
                    if (sub < 3)
                        ids_reg = {ids_reg[15:0], b};
                    else if (sub < 11)
                        seq_reg = {seq_reg[55:0], b};
                    else
                        msg_left = {msg_left[15:0], b};
                    if (sub >= 13)
                    begin
                        if (32'(msg_left) > region_end - pos - 32'd1)
                            abandon_frame();
                        else
                        begin
                            batch.push_back(make_record(pfd_pkg::KIND_HEADER, 8'h00, 1'b0,
                                                        pfd_pkg::ST_OK));
                            close_element(pos, region_end);
                        end
                    end
                    else
                        elem_idx = 16'(sub + 1);
                end
            end
            PH_ELEN_HI:
            begin
                if (msg_left < 2)
                    abandon_frame();
                else
                begin
                    elem_idx = {b, 8'h00};
                    msg_left = msg_left - 24'd1;
                    ph = PH_ELEN_LO;
                end
            end
            PH_ELEN_LO:
            begin
                elem_idx = elem_idx | {8'h00, b};
                msg_left = msg_left - 24'd1;
                if (24'(elem_idx) > msg_left)
                    abandon_frame();
                else if (elem_idx == 0)
                    close_element(pos, region_end);
                else
                    ph = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                elem_idx = elem_idx - 16'd1;
                msg_left = msg_left - 24'd1;
                batch.push_back(make_record(pfd_pkg::KIND_PAYLOAD, b, elem_idx == 0,
                                            pfd_pkg::ST_OK));
                if (elem_idx == 0)
                    close_element(pos, region_end);
            end
            PH_TRAILER:
            begin
                sub = 32'(elem_idx);
                if (sub == 3)
                    crc_rx = tail_reg[31:0];
                if (sub >= 7)
                    ph = PH_TAIL;
                else
                    elem_idx = 16'(sub + 1);
            end
            default:
            begin
            end
        endcase

        // Frame status, in order of precedence.
        if (lst)
        begin
            if (byte_cnt < 8)
                st = pfd_pkg::ST_SHORT;
            else if (err_flags[0] || tail_reg[31:0] != pfd_pkg::EOF_WORD)
                st = pfd_pkg::ST_SOF_EOF;
            else if (err_flags[1] || ph != PH_TAIL)
                st = pfd_pkg::ST_LENGTH;
            else if (~crc_reg != crc_rx)
                st = pfd_pkg::ST_CRC;
            else
                st = pfd_pkg::ST_OK;
            batch.push_back(make_record(pfd_pkg::KIND_STATUS, 8'h00, 1'b0, st));
            parser_clear();
        end

        if (batch.size() > 0)
            batch[batch.size() - 1].out_last = 1'b1;
        foreach (batch[i])
            expected_results.push_back(batch[i]);
    endfunction

    // Build a well-formed frame into frame_bytes, optionally with a bent length field.
    function automatic void build_frame(input int n_msgs, input bit bend_struct);
        logic [7:0]  body[$];
        logic [7:0]  hdr[4];
        logic [31:0] c;
        logic [15:0] app;
        logic [15:0] elen;
        logic [63:0] seq;
        logic [23:0] m_len;
        logic [23:0] l_len;
        logic [7:0]  bump;
        int          len_pos;
        int          n_el;
        int          target;
        frame_bytes.delete();
        for (int m = 0; m < n_msgs; m++)
        begin
            case ($urandom_range(0, 9))
                0: app = 16'hffff;
                1: app = 16'h0000;
                default: app = 16'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0: seq = '1;
                1: seq = '0;
                default: seq = {$urandom, $urandom};
            endcase
            body.push_back(app[15:8]);
            body.push_back(app[7:0]);
            body.push_back(8'($urandom));
            for (int k = 7; k >= 0; k--)
                body.push_back(seq[8*k +: 8]);
            len_pos = body.size();
            repeat (3) body.push_back(8'h00);
            m_len = '0;
            n_el = $urandom_range(0, 3);
            for (int e = 0; e < n_el; e++)
            begin
                case ($urandom_range(0, 19))
                    0: elen = 16'd0;
                    1, 2, 3: elen = 16'($urandom_range(9, 40));
                    default: elen = 16'($urandom_range(1, 8));
                endcase
                body.push_back(elen[15:8]);
                body.push_back(elen[7:0]);
                for (int i = 0; i < int'(elen); i++)
                    body.push_back(8'($urandom));
                m_len = m_len + 24'd2 + 24'(elen);
            end
            body[len_pos]     = m_len[23:16];
            body[len_pos + 1] = m_len[15:8];
            body[len_pos + 2] = m_len[7:0];
        end
        l_len = 24'(body.size());
        hdr[0] = 8'($urandom);
        hdr[1] = l_len[23:16];
        hdr[2] = l_len[15:8];
        hdr[3] = l_len[7:0];

        // Nudge the packet, message or element length; the CRC still matches.
        if (bend_struct)
        begin
            bump = 8'($urandom_range(1, 3));
            if ($urandom_range(0, 1))
                bump = -bump;
            target = $urandom_range(0, 2);
            if (target == 1 && body.size() >= 14)
                body[13] = body[13] + bump;
            else if (target == 2 && body.size() >= 16)
                body[15] = body[15] + bump;
            else
                hdr[3] = hdr[3] + bump;
        end

        c = pfd_pkg::CRC_INIT;
        foreach (hdr[i])
            c = crc_update(c, hdr[i]);
        foreach (body[i])
            c = crc_update(c, body[i]);
        c = ~c;
        for (int i = 0; i < 4; i++)
            frame_bytes.push_back(pfd_pkg::SOF_BYTES[i]);
        foreach (hdr[i])
            frame_bytes.push_back(hdr[i]);
        foreach (body[i])
            frame_bytes.push_back(body[i]);
        for (int k = 3; k >= 0; k--)
            frame_bytes.push_back(c[8*k +: 8]);
        for (int k = 3; k >= 0; k--)
            frame_bytes.push_back(pfd_pkg::EOF_WORD[8*k +: 8]);
    endfunction

    // Queue frame_bytes for sending, drawing the gap before each byte.
    task automatic queue_frame(input int gap_mode, input bit drain);
        int unsigned g;
        foreach (frame_bytes[i])
        begin
            case (gap_mode)
                0: g = 0;
                1: g = $urandom_range(0, 16);
                default: g = $urandom_range(0, 2);
            endcase
            pending_bytes.push_back('{data: frame_bytes[i], lst: (i == frame_bytes.size() - 1),
                                      gap: g, drain: drain && (i == 0)});
        end
    endtask

    // Sender: offers queued bytes and predicts the records of each accepted one.
    always @(posedge clk or negedge rst_n)
    begin : sender
        frame_byte_t item;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
            in_last  <= 1'b0;
            parser_clear();
        end
        else
        begin
            if (in_valid && in_ready)
                predict_records(in_byte, in_last);
            if (!in_valid || in_ready)
            begin
                if (pending_bytes.size() == 0)
                    in_valid <= 1'b0;
                else if (pending_bytes[0].gap != 0)
                begin
                    pending_bytes[0].gap = pending_bytes[0].gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes[0].drain && expected_results.size() != 0)
                    in_valid <= 1'b0;
                else
                begin
                    item = pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    in_byte  <= item.data;
                    in_last  <= item.lst;
                end
            end
        end
    end

    // Receiver: stalls at random, once for a long stretch, and checks every record.
    always @(posedge clk or negedge rst_n)
    begin : receiver
        pfd_pkg::res_t got;
        pfd_pkg::res_t want;
        int unsigned   w;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait = 0;
        end
        else if (out_valid && out_ready)
        begin
            got = {kind, app_id, step_id, msg_version, seq_id, payload_byte,
                   element_end, frame_version, status, out_last};
            if (expected_results.size() == 0)
            begin
                $error("unexpected record: kind %0d, status %0d", got.kind, got.status);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.kind != want.kind)
                begin
                    $error("kind: expected %0h, got %0h", want.kind, got.kind);
                    errors++;
                end
                if (got.app_id != want.app_id)
                begin
                    $error("app_id: expected %0h, got %0h", want.app_id, got.app_id);
                    errors++;
                end
                if (got.step_id != want.step_id)
                begin
                    $error("step_id: expected %0h, got %0h", want.step_id, got.step_id);
                    errors++;
                end
                if (got.msg_version != want.msg_version)
                begin
                    $error("msg_version: expected %0h, got %0h", want.msg_version,
                           got.msg_version);
                    errors++;
                end
                if (got.seq_id != want.seq_id)
                begin
                    $error("seq_id: expected %0h, got %0h", want.seq_id, got.seq_id);
                    errors++;
                end
                if (got.payload_byte != want.payload_byte)
                begin
                    $error("payload_byte: expected %0h, got %0h", want.payload_byte,
                           got.payload_byte);
                    errors++;
                end
                if (got.element_end != want.element_end)
                begin
                    $error("element_end: expected %0h, got %0h", want.element_end,
                           got.element_end);
                    errors++;
                end
                if (got.frame_version != want.frame_version)
                begin
                    $error("frame_version: expected %0h, got %0h", want.frame_version,
                           got.frame_version);
                    errors++;
                end
                if (got.status != want.status)
                begin
                    $error("status: expected %0h, got %0h", want.status, got.status);
                    errors++;
                end
                if (got.out_last != want.out_last)
                begin
                    $error("out_last: expected %0h, got %0h", want.out_last, got.out_last);
                    errors++;
                end
            end
            results_seen++;

            // One long hold-off lets the result queue fill and back up the input.
            if (results_seen == HOLD_AT)
            begin
                out_ready <= 1'b0;
                rx_wait = HOLD_CYCLES;
            end
            else
            begin
                if (results_seen % 64 == 0)
                    rx_mode = $urandom_range(0, 2);
                case (rx_mode)
                    0: w = 0;
                    1: w = $urandom_range(0, 16);
                    default: w = $urandom_range(0, 2);
                endcase
                if (w == 0)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready <= 1'b0;
                    rx_wait = w - 1;
                end
            end
        end
        else if (!out_ready)
        begin
            if (rx_wait == 0)
                out_ready <= 1'b1;
            else
                rx_wait = rx_wait - 1;
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int unsigned random_bytes;
        int          frame_no;
        int          gap_mode;
        int          idx;
        int          keep;
        int          n;
        random_bytes = 0;
        frame_no = 0;

        // Directed: a lone byte and a seven-byte frame are too short; then an empty packet.
        frame_bytes.delete();
        frame_bytes.push_back(8'hff);
        queue_frame(0, 1'b0);
        frame_bytes.delete();
        for (int i = 0; i < 4; i++)
            frame_bytes.push_back(pfd_pkg::SOF_BYTES[i]);
        frame_bytes.push_back(8'h0f);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h00);
        queue_frame(0, 1'b0);
        build_frame(0, 1'b0);
        queue_frame(0, 1'b0);

        // Random frames: mostly well formed, the rest damaged in one way or another.
        while (random_bytes < RANDOM_BYTES)
        begin
            build_frame($urandom_range(0, 3), $urandom_range(0, 9) == 0);
            case ($urandom_range(0, 19))
                0:
                    frame_bytes[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
                1:
                begin
                    idx = frame_bytes.size() - 1 - $urandom_range(0, 3);
                    frame_bytes[idx] ^= 8'(1 << $urandom_range(0, 7));
                end
                2:
                begin
                    idx = frame_bytes.size() - 5 - $urandom_range(0, 3);
                    frame_bytes[idx] ^= 8'(1 << $urandom_range(0, 7));
                end
                3, 4:
                begin
                    idx = $urandom_range(4, frame_bytes.size() - 9);
                    frame_bytes[idx] ^= 8'(1 << $urandom_range(0, 7));
                end
                5:
                begin
                    keep = $urandom_range(1, frame_bytes.size() - 1);
                    while (frame_bytes.size() > keep)
                        void'(frame_bytes.pop_back());
                end
                6:
                begin
                    // Bytes after the CRC are ignored as long as the EOF closes the frame.
                    n = $urandom_range(1, 6);
                    repeat (n)
                        frame_bytes.insert(frame_bytes.size() - 4, 8'($urandom));
                end
                7:
                    frame_bytes.delete($urandom_range(4, frame_bytes.size() - 5));
                8:
                begin
                    n = $urandom_range(1, 40);
                    frame_bytes.delete();
                    if ($urandom_range(0, 1))
                        for (int i = 0; i < 4; i++)
                            frame_bytes.push_back(pfd_pkg::SOF_BYTES[i]);
                    repeat (n)
                        frame_bytes.push_back(8'($urandom));
                end
                default:
                begin
                end
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap_mode = 0;
                4, 5, 6: gap_mode = 1;
                default: gap_mode = 2;
            endcase
            queue_frame(gap_mode, frame_no % 10 == 5);
            random_bytes += frame_bytes.size();
            frame_no++;
        end

        // Reset, released away from the clock edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
